FILE: rtl/core/mrqb_pkg.sv
package mrqb_pkg;

   localparam int NUM_QUEUES = 16;
   localparam int MAX_SLOTS  = 64;
   localparam int QIDX_W     = $clog2(NUM_QUEUES);
   localparam int PTR_W      = $clog2(MAX_SLOTS);
   localparam int SLOTS_W    = 7;
   localparam int WORD_W     = 64;
   localparam int ADDR_W     = QIDX_W + PTR_W;
   localparam int CMD_DEPTH  = 2;
   localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);

   localparam logic [SLOTS_W-1:0] SLOTS_RESET = SLOTS_W'(MAX_SLOTS);
   localparam logic [SLOTS_W-1:0] SLOTS_MIN   = SLOTS_W'(2);
   localparam logic [SLOTS_W-1:0] SLOTS_MAX   = SLOTS_W'(MAX_SLOTS);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic              take;
      logic              write;
      logic              status;
      logic [ADDR_W-1:0] addr;
      logic [WORD_W-1:0] value;
   } cmd_type;

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                input logic [SLOTS_W-1:0] slots);
      logic [SLOTS_W-1:0] n;
      n = SLOTS_W'(p) + SLOTS_W'(1);
      return (n >= slots) ? '0 : PTR_W'(n);
   endfunction

endpackage

FILE: rtl/core/mrqb_if.sv
interface mrqb_req_if;
   import mrqb_pkg::*;
   logic              valid;
   logic              ready;
   logic              operation;
   logic [QIDX_W-1:0] queue_index;
   logic [WORD_W-1:0] push_value;

   modport source(output valid, operation, queue_index, push_value, input ready);
   modport sink(input valid, operation, queue_index, push_value, output ready);
endinterface

interface mrqb_rsp_if;
   import mrqb_pkg::*;
   logic              valid;
   logic              ready;
   logic              status;
   logic [WORD_W-1:0] taken_value;

   modport source(output valid, status, taken_value, input ready);
   modport sink(input valid, status, taken_value, output ready);
endinterface

FILE: rtl/core/multi_ring_queue_bank.sv
// A transaction accepted from the request side is written into the command queue, then
// popped into the response register, where it is held until the response side is ready.
// Throughput: one transaction per cycle while responses are taken, set by the single-port
// slot memory and the two-entry command queue between the pointer logic and the memory.
// Reset clears all queue pointers, sets the slot count to 64 and empties the command
// queue and the response register; the slot memory is not cleared.
module multi_ring_queue_bank (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [mrqb_pkg::SLOTS_W-1:0] csr_write_data,
   mrqb_req_if.sink                     req,
   mrqb_rsp_if.source                   rsp
);
   import mrqb_pkg::*;

   cmd_type fe_cmd, be_cmd;
   logic    fe_push, cmd_full, cmd_empty, be_pop;

   mrqb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req),
      .cmd_full         (cmd_full),
      .cmd_push         (fe_push),
      .cmd_data         (fe_cmd)
   );

   mrqb_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fe_push),
      .push_data (fe_cmd),
      .full      (cmd_full),
      .pop       (be_pop),
      .empty     (cmd_empty),
      .pop_data  (be_cmd)
   );

   mrqb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (be_cmd),
      .cmd_pop   (be_pop),
      .rsp       (rsp)
   );

endmodule

FILE: rtl/core/mrqb_cmd_fifo.sv
module mrqb_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mrqb_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output mrqb_pkg::cmd_type pop_data
);
   import mrqb_pkg::*;

   cmd_type                entry_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop)) else $error("command queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("command queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMD_CNT_W'(CMD_DEPTH)) else $error("command queue count out of range");

endmodule

FILE: rtl/core/mrqb_front.sv
module mrqb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [mrqb_pkg::SLOTS_W-1:0]  csr_write_data,
   mrqb_req_if.sink                      req,
   input  logic                          cmd_full,
   output logic                          cmd_push,
   output mrqb_pkg::cmd_type             cmd_data
);
   import mrqb_pkg::*;

   logic [SLOTS_W-1:0] slots_ff;
   logic [SLOTS_W-1:0] eff_slots;
   logic [PTR_W-1:0]   wp_ff [NUM_QUEUES];
   logic [PTR_W-1:0]   rp_ff [NUM_QUEUES];
   logic [PTR_W-1:0]   wp_cur, rp_cur, wp_next;
   logic               accept, push_ok, take_ok;

   assign req.ready = !cmd_full && !reset;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (slots_ff < SLOTS_MIN) begin
         eff_slots = SLOTS_MIN;
      end else if (slots_ff > SLOTS_MAX) begin
         eff_slots = SLOTS_MAX;
      end else begin
         eff_slots = slots_ff;
      end
   end

   assign wp_cur  = wp_ff[req.queue_index];
   assign rp_cur  = rp_ff[req.queue_index];
   assign wp_next = advance(wp_cur, eff_slots);
   assign push_ok = (req.operation == OP_PUSH) && (wp_next != rp_cur);
   assign take_ok = (req.operation == OP_TAKE) && (wp_cur != rp_cur);

   always_comb begin
      cmd_push        = accept;
      cmd_data.take   = take_ok;
      cmd_data.write  = push_ok;
      cmd_data.status = (push_ok || take_ok) ? STATUS_OK : STATUS_REFUSED;
      cmd_data.addr   = {req.queue_index, (req.operation == OP_PUSH) ? wp_cur : rp_cur};
      cmd_data.value  = req.push_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
         for (int i = 0; i < NUM_QUEUES; i++) begin
            wp_ff[i] <= '0;
            rp_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            slots_ff <= csr_write_data;
         end
         if (accept && push_ok) begin
            wp_ff[req.queue_index] <= wp_next;
         end
         if (accept && take_ok) begin
            rp_ff[req.queue_index] <= advance(rp_cur, eff_slots);
         end
      end
   end

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      accept && push_ok |=> wp_ff[$past(req.queue_index)] != rp_ff[$past(req.queue_index)])
      else $error("queue reads empty after a successful push");
   a_ok_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(push_ok && take_ok)) else $error("push and take both granted");

endmodule

FILE: rtl/core/mrqb_back.sv
module mrqb_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_empty,
   input  mrqb_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   mrqb_rsp_if.source        rsp
);
   import mrqb_pkg::*;

   logic [WORD_W-1:0] store [NUM_QUEUES * MAX_SLOTS];
   logic [WORD_W-1:0] rd_data_ff;
   logic              valid_ff, valid_in;
   logic              status_ff;
   logic              take_ff;

   assign cmd_pop  = !cmd_empty && (!valid_ff || rsp.ready);
   assign valid_in = cmd_pop || (valid_ff && !rsp.ready);

   assign rsp.valid       = valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.taken_value = take_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         status_ff <= cmd_data.status;
         take_ff   <= cmd_data.take;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop && cmd_data.write) begin
         store[cmd_data.addr] <= cmd_data.value;
      end
      if (cmd_pop && cmd_data.take) begin
         rd_data_ff <= store[cmd_data.addr];
      end
   end

   a_refused_is_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd_data.status == STATUS_REFUSED |-> !cmd_data.write && !cmd_data.take)
      else $error("refused command touches the store");

endmodule

FILE: verif/tb_multi_ring_queue_bank.sv
module tb_multi_ring_queue_bank;
   import mrqb_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_HOLD   = 60;
   localparam int DRAIN_WAIT  = 4;
   localparam int NUM_ROWS    = 28;
   localparam int NUM_PHASES  = 10;

   typedef enum logic [1:0] {STEP_PUSH, STEP_TAKE, STEP_SLOTS} step_kind_type;

   typedef struct packed {
      step_kind_type     kind;
      logic [QIDX_W-1:0] queue_index;
      logic [WORD_W-1:0] value;
      bit                typed;
      logic              status;
      logic [WORD_W-1:0] taken;
   } directed_row_type;

   typedef struct packed {
      logic [SLOTS_W-1:0] slots;
      int unsigned        count;
      int unsigned        fill_len;
      bit                 steady;
      bit                 hold;
   } phase_type;

   typedef struct packed {
      logic              status;
      logic [WORD_W-1:0] taken;
   } outcome_type;

   localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

   localparam directed_row_type DIRECTED [NUM_ROWS] = '{
      '{STEP_TAKE,  4'd0,  64'd0,                 1'b1, STATUS_REFUSED, 64'd0},
      '{STEP_PUSH,  4'd0,  ONES,                  1'b1, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd15, 64'd0,                 1'b1, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd0,  64'd0,                 1'b1, STATUS_OK,      ONES},
      '{STEP_TAKE,  4'd15, ONES,                  1'b1, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd15, 64'd0,                 1'b1, STATUS_REFUSED, 64'd0},
      '{STEP_SLOTS, 4'd0,  64'd2,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd3,  64'hA5A5A5A5A5A5A5A5,  1'b1, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd3,  64'h5A5A5A5A5A5A5A5A,  1'b1, STATUS_REFUSED, 64'd0},
      '{STEP_TAKE,  4'd3,  64'd0,                 1'b1, STATUS_OK,      64'hA5A5A5A5A5A5A5A5},
      '{STEP_TAKE,  4'd3,  64'd0,                 1'b1, STATUS_REFUSED, 64'd0},
      '{STEP_PUSH,  4'd3,  64'h0123456789ABCDEF,  1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd3,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_SLOTS, 4'd0,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd4,  64'h1111111111111111,  1'b1, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd4,  64'h2222222222222222,  1'b1, STATUS_REFUSED, 64'd0},
      '{STEP_SLOTS, 4'd0,  64'd127,               1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd4,  64'h3333333333333333,  1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd4,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd4,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd5,  64'h8000000000000001,  1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd5,  64'h7FFFFFFFFFFFFFFE,  1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd5,  64'h0F0F0F0F0F0F0F0F,  1'b0, STATUS_OK,      64'd0},
      '{STEP_SLOTS, 4'd0,  64'd3,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_PUSH,  4'd5,  64'hFEDCBA9876543210,  1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd5,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd5,  64'd0,                 1'b0, STATUS_OK,      64'd0},
      '{STEP_TAKE,  4'd5,  64'd0,                 1'b0, STATUS_OK,      64'd0}
   };

   localparam phase_type PHASES [NUM_PHASES] = '{
      '{7'd64,  50,  0,  1'b0, 1'b0},
      '{7'd2,   50,  0,  1'b1, 1'b0},
      '{7'd127, 120, 75, 1'b0, 1'b0},
      '{7'd5,   60,  0,  1'b1, 1'b1},
      '{7'd0,   40,  0,  1'b0, 1'b0},
      '{7'd17,  60,  20, 1'b0, 1'b0},
      '{7'd1,   30,  0,  1'b0, 1'b0},
      '{7'd63,  60,  0,  1'b0, 1'b0},
      '{7'd3,   60,  0,  1'b0, 1'b0},
      '{7'd64,  70,  0,  1'b0, 1'b0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable;
   logic [SLOTS_W-1:0] csr_write_data;

   mrqb_req_if req_ch ();
   mrqb_rsp_if rsp_ch ();

   multi_ring_queue_bank u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req              (req_ch),
      .rsp              (rsp_ch)
   );

   always #1 clock = ~clock;

   logic [SLOTS_W-1:0] slots_setting;
   logic [PTR_W-1:0]   write_pos [NUM_QUEUES];
   logic [PTR_W-1:0]   read_pos [NUM_QUEUES];
   logic [WORD_W-1:0]  ring_words [NUM_QUEUES*MAX_SLOTS];
   bit                 word_written [NUM_QUEUES*MAX_SLOTS];

   outcome_type pending_outcomes [$];
   int          mismatch_count = 0;
   bit          steady = 1'b0;
   bit          long_hold = 1'b0;

   function automatic logic [SLOTS_W-1:0] ring_length();
      if (slots_setting < SLOTS_MIN) return SLOTS_MIN;
      if (slots_setting > SLOTS_MAX) return SLOTS_MAX;
      return slots_setting;
   endfunction

   function automatic logic [PTR_W-1:0] next_position(input logic [PTR_W-1:0] pos);
      logic [SLOTS_W-1:0] bumped;
      bumped = SLOTS_W'(pos) + SLOTS_W'(1);
      return (bumped >= ring_length()) ? '0 : bumped[PTR_W-1:0];
   endfunction

   function automatic bit reads_blank_slot(input logic [QIDX_W-1:0] q);
      return write_pos[q] != read_pos[q] && !word_written[{q, read_pos[q]}];
   endfunction

   function automatic outcome_type apply_request(input logic op, input logic [QIDX_W-1:0] q,
                                                 input logic [WORD_W-1:0] value);
      outcome_type      result;
      logic [PTR_W-1:0] advanced;
      result = '{STATUS_REFUSED, '0};
      if (op == OP_PUSH) begin
         advanced = next_position(write_pos[q]);
         if (advanced != read_pos[q]) begin
            ring_words[{q, write_pos[q]}] = value;
            word_written[{q, write_pos[q]}] = 1'b1;
            write_pos[q] = advanced;
            result.status = STATUS_OK;
         end
      end else if (write_pos[q] != read_pos[q]) begin
         result = '{STATUS_OK, ring_words[{q, read_pos[q]}]};
         read_pos[q] = next_position(read_pos[q]);
      end
      return result;
   endfunction

   task automatic offer_request(input logic op, input logic [QIDX_W-1:0] q,
                                input logic [WORD_W-1:0] value, input bit typed,
                                input outcome_type typed_outcome);
      int          gap;
      outcome_type predicted;
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= op;
      req_ch.queue_index <= q;
      req_ch.push_value  <= value;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_request(op, q, value);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic set_slot_count(input logic [SLOTS_W-1:0] slots);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data   <= slots;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slots_setting = slots;
   endtask

   initial begin
      directed_row_type  row;
      logic              op;
      logic [QIDX_W-1:0] q;
      logic [QIDX_W-1:0] hot_queue;
      logic [WORD_W-1:0] value;
      int unsigned       push_pct;
      int unsigned       hot_pct;
      int unsigned       pick;

      req_ch.valid       <= 1'b0;
      req_ch.operation   <= OP_PUSH;
      req_ch.queue_index <= '0;
      req_ch.push_value  <= '0;
      csr_write_enable   <= 1'b0;
      csr_write_data     <= '0;
      slots_setting = SLOTS_RESET;
      for (int i = 0; i < NUM_QUEUES; i++) begin
         write_pos[i] = '0;
         read_pos[i]  = '0;
      end
      for (int i = 0; i < NUM_QUEUES*MAX_SLOTS; i++) begin
         ring_words[i]   = '0;
         word_written[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row = DIRECTED[r];
         if (row.kind == STEP_SLOTS) begin
            set_slot_count(row.value[SLOTS_W-1:0]);
         end else begin
            offer_request(row.kind == STEP_TAKE ? OP_TAKE : OP_PUSH, row.queue_index,
                          row.value, row.typed, '{row.status, row.taken});
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         steady = 1'b0;
         set_slot_count(PHASES[p].slots);
         steady    = PHASES[p].steady;
         long_hold = PHASES[p].hold;
         hot_queue = QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
         for (int unsigned i = 0; i < PHASES[p].count; i++) begin
            if (i < PHASES[p].fill_len) begin
               push_pct = 95;
               hot_pct  = 100;
            end else begin
               push_pct = ((i / 15) % 2 == 0) ? 75 : 30;
               hot_pct  = 70;
            end
            q  = ($urandom_range(0, 99) < hot_pct) ? hot_queue
                                                   : QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TAKE;
            if (op == OP_TAKE && reads_blank_slot(q)) op = OP_PUSH;
            pick = $urandom_range(0, 15);
            if (pick == 0) value = '0;
            else if (pick == 1) value = ONES;
            else value = {$urandom, $urandom};
            offer_request(op, q, value, 1'b0, '0);
         end
      end

      steady = 1'b0;
      drain_responses();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      int wait_cycles;
      rsp_ch.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold = 1'b0;
         end else begin
            wait_cycles = steady ? 0 : $urandom_range(0, 13);
            if (wait_cycles > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (wait_cycles) @(posedge clock);
            end
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      outcome_type head;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Response with no transaction waiting: status %0d taken_value %h",
                        rsp_ch.status, rsp_ch.taken_value);
            end
         end else begin
            head = pending_outcomes.pop_front();
            if (rsp_ch.status !== head.status || rsp_ch.taken_value !== head.taken) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: status expected %0d got %0d, taken_value expected %h got %h",
                           head.status, rsp_ch.status, head.taken, rsp_ch.taken_value);
               end
            end
         end
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

FILE: multi_ring_queue_bank.f
rtl/core/mrqb_pkg.sv
rtl/core/mrqb_if.sv
rtl/core/mrqb_cmd_fifo.sv
rtl/core/mrqb_front.sv
rtl/core/mrqb_back.sv
rtl/core/multi_ring_queue_bank.sv
verif/tb_multi_ring_queue_bank.sv
